>>> hw/rtl/tlttb_pkg.sv
package tlttb_pkg;

  localparam int COLUMNS = 16;
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ADDR_W = COL_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  localparam logic [7:0] CH_RETURN = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_DELETE = 8'd127;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

>>> hw/rtl/tlttb_if.sv
interface tlttb_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tlttb_cell_if;
  logic       valid;
  logic       ready;
  logic       cell_row;
  logic [3:0] cell_col;
  logic [7:0] cell_char;
  logic       cursor_row;
  logic [3:0] cursor_col;
  logic       last_cell;

  modport source (
    output valid, output cell_row, output cell_col, output cell_char,
    output cursor_row, output cursor_col, output last_cell, input ready
  );
  modport sink (
    input valid, input cell_row, input cell_col, input cell_char,
    input cursor_row, input cursor_col, input last_cell, output ready
  );
endinterface

>>> hw/rtl/two_line_text_terminal_buffer_top.sv
// Two-line terminal screen buffer. Each received byte updates the screen and
// cursor in the cycle it is accepted, and then all 2*COLUMNS cells are sent
// out, line 0 first, each carrying the new cursor position, the final one
// flagged by last_cell. After a byte is accepted, the first cell is read from
// the character memory into a read register and then loaded into the output
// register; cells follow at one per cycle through the single read port while
// the output is not stalled. A new byte is taken only after the last cell of
// the previous refresh has been delivered. A per-cell valid bit marks cells
// that hold a written character; cleared cells read as spaces, so reset and
// line blanking take effect at once and no clearing pass is needed.
module two_line_text_terminal_buffer_top
  import tlttb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  tlttb_rx_if.sink      rx_ch,
  tlttb_cell_if.source  cell_ch
);

  state_t state;
  state_t state_next;

  logic [7:0]               mem [MEM_DEPTH];
  logic [1:0][COLUMNS-1:0]  valid;
  logic [1:0][COLUMNS-1:0]  valid_next;

  logic             cur_row;
  logic [COL_W-1:0] cur_col;

  logic             scan_row;
  logic [COL_W-1:0] scan_col;
  logic             issue_busy;

  logic             pend;
  logic [7:0]       rdata;
  logic             rvalid;
  logic             row1;
  logic [COL_W-1:0] col1;
  logic             last1;

  logic             out_valid;
  logic             out_row;
  logic [COL_W-1:0] out_col;
  logic [7:0]       out_char;
  logic             out_last;

  logic             accept;
  logic             advance;
  logic             issue;
  logic             scan_last;
  logic             is_return;
  logic             is_delete;
  logic [7:0]       wr_char;
  logic             row_next;
  logic [COL_W-1:0] col_next;
  logic             blank_row;

  assign accept    = rx_ch.valid && rx_ch.ready;
  assign advance   = pend && (!out_valid || cell_ch.ready);
  assign issue     = (state == ST_SCAN) && issue_busy && (!pend || advance);
  assign scan_last = scan_row && (scan_col == LAST_COL);

  // The new cursor and the cell writes follow from the byte and the current cursor.
  always_comb begin
    is_return = (rx_ch.rx_byte == CH_RETURN);
    is_delete = rx_ch.rx_byte inside {CH_BACKSPACE, CH_DELETE};
    wr_char   = (is_return || is_delete) ? CH_SPACE : rx_ch.rx_byte;
    row_next  = cur_row;
    col_next  = cur_col;
    blank_row = 1'b0;
    if (is_return) begin
      row_next  = !cur_row;
      col_next  = '0;
      blank_row = 1'b1;
    end else if (is_delete) begin
      if (cur_col == '0) begin
        row_next = !cur_row;
        col_next = LAST_COL;
      end else begin
        col_next = cur_col - COL_W'(1);
      end
    end else if (cur_col == LAST_COL) begin
      row_next  = !cur_row;
      col_next  = '0;
      blank_row = 1'b1;
    end else begin
      col_next = cur_col + COL_W'(1);
    end
  end

  always_comb begin
    valid_next = valid;
    if (accept) begin
      valid_next[cur_row][cur_col] = !(is_return || is_delete);
      if (blank_row) begin
        valid_next[row_next] = '0;
      end
      if (is_delete) begin
        valid_next[row_next][col_next] = 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (out_valid && cell_ch.ready && out_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rx_ch.ready        = (state == ST_IDLE);
    cell_ch.valid      = out_valid;
    cell_ch.cell_row   = out_row;
    cell_ch.cell_col   = 4'(out_col);
    cell_ch.cell_char  = out_char;
    cell_ch.cursor_row = cur_row;
    cell_ch.cursor_col = 4'(cur_col);
    cell_ch.last_cell  = out_last;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[{cur_row, cur_col}] <= wr_char;
    end
    if (issue) begin
      rdata <= mem[{scan_row, scan_col}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur_row    <= 1'b0;
      cur_col    <= '0;
      issue_busy <= 1'b0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
      valid      <= '0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      if (accept) begin
        cur_row    <= row_next;
        cur_col    <= col_next;
        issue_busy <= 1'b1;
      end
      if (issue) begin
        pend <= 1'b1;
        if (scan_last) begin
          issue_busy <= 1'b0;
        end
      end else if (advance) begin
        pend <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (cell_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_row <= 1'b0;
      scan_col <= '0;
    end else if (issue) begin
      if (scan_col == LAST_COL) begin
        scan_col <= '0;
        scan_row <= 1'b1;
      end else begin
        scan_col <= scan_col + COL_W'(1);
      end
    end
    if (issue) begin
      rvalid <= valid[scan_row][scan_col];
      row1   <= scan_row;
      col1   <= scan_col;
      last1  <= scan_last;
    end
    if (advance) begin
      out_row  <= row1;
      out_col  <= col1;
      out_char <= rvalid ? rdata : CH_SPACE;
      out_last <= last1;
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rx_ch.valid && rx_ch.ready |-> !cell_ch.valid && !pend)
    else $error("request accepted while a refresh is still in flight");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    cell_ch.valid && cell_ch.ready && cell_ch.last_cell |=> rx_ch.ready)
    else $error("not ready for a request after the final cell");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    rx_ch.valid && rx_ch.ready |=> !rx_ch.ready && issue_busy)
    else $error("refresh did not start after a request");
`endif

endmodule
